// ----- rtl/core/lci_pkg.sv -----
package lci_pkg;

  // Default widths of the level and radius words (Q16.16)
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Depth of the job queue between the classifier and the interpolation unit
  localparam int JOB_DEPTH = 2;

  // Number of words in one job: numerator, denominator, low radius, high radius
  localparam int JOB_WORDS = 4;

endpackage

// ----- rtl/core/level_crossing_interpolator_top.sv -----
// Level crossing interpolator. Profile points (signed level, unsigned radius,
// fixed point with FRACTION_BITS fraction bits) are pushed in; whenever the
// segment from the stored point to the new one reaches or crosses target_level,
// one crossing_radius is produced by linear interpolation, in input order.
// Points that form no crossing are taken one per cycle while the job queue
// has room. Each crossing occupies the interpolation unit: a radix-2
// restoring divider giving one weight bit per cycle (17 bits at Q16.16), then
// one multiply, one add and the hand-over to the output register. A two-entry
// job queue lets new points be taken while the divider is busy and while a
// result waits to be popped. Write target_level only when idle.
module level_crossing_interpolator_top #(
  parameter int VALUE_WIDTH   = lci_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = lci_pkg::FRACTION_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic signed [VALUE_WIDTH-1:0] target_level,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] sample_level,
  input  logic        [VALUE_WIDTH-1:0] sample_radius,
  input  logic                          first_point,
  input  logic                          pop,
  output logic                          empty,
  output logic        [VALUE_WIDTH-1:0] crossing_radius
);

  import lci_pkg::*;

  localparam int JOB_W = JOB_WORDS * VALUE_WIDTH;

  logic             job_full, job_empty, job_push, job_pop;
  logic [JOB_W-1:0] job_in, job_out;

  // Classifier and point store
  lci_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .target_level  (target_level),
    .push          (push),
    .full          (full),
    .sample_level  (sample_level),
    .sample_radius (sample_radius),
    .first_point   (first_point),
    .job_full      (job_full),
    .job_push      (job_push),
    .job_data      (job_in)
  );

  // Job queue between the two halves
  lci_job_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .q_full  (job_full),
    .rd_en   (job_pop),
    .rd_data (job_out),
    .q_empty (job_empty)
  );

  // Interpolation unit and result register
  lci_back #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS),
    .JOB_W         (JOB_W)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .job_empty       (job_empty),
    .job_data        (job_out),
    .job_pop         (job_pop),
    .pop             (pop),
    .empty           (empty),
    .crossing_radius (crossing_radius)
  );

endmodule

// ----- rtl/core/lci_front.sv -----
module lci_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int JOB_W       = 4 * 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic signed [VALUE_WIDTH-1:0] target_level,
  input  logic                          push,
  output logic                          full,
  input  logic signed [VALUE_WIDTH-1:0] sample_level,
  input  logic        [VALUE_WIDTH-1:0] sample_radius,
  input  logic                          first_point,
  input  logic                          job_full,
  output logic                          job_push,
  output logic        [JOB_W-1:0]       job_data
);

  import lci_pkg::*;

  localparam int W = VALUE_WIDTH;

  logic signed [W-1:0] target;
  logic signed [W-1:0] previous_level;
  logic        [W-1:0] previous_radius;
  logic                have_previous;

  logic signed [W:0] prev_x, cur_x, tgt_x;
  logic signed [W:0] diff_prev, diff_cur, diff_pc, diff_cp;
  logic signed [W:0] num_sel, den_sel;
  logic              accept, hit, swap;
  logic [W-1:0]      job_num, job_den, job_ylo, job_yhi;

  // Transfer on the input side needs room for a possible job
  assign full   = job_full;
  assign accept = push && !full;

  // Differences one bit wider so they are always exact
  assign prev_x    = {previous_level[W-1], previous_level};
  assign cur_x     = {sample_level[W-1], sample_level};
  assign tgt_x     = {target[W-1], target};
  assign diff_prev = prev_x - tgt_x;
  assign diff_cur  = cur_x - tgt_x;
  assign diff_pc   = prev_x - cur_x;
  assign diff_cp   = cur_x - prev_x;

  // Segment touches or crosses the target
  assign hit = have_previous && !first_point &&
               ((diff_prev == '0) || (diff_cur == '0) || (diff_prev[W] != diff_cur[W]));

  // Swap only when the previous level is strictly the higher one
  assign swap    = !diff_pc[W] && (diff_pc != '0);
  assign num_sel = swap ? diff_prev : diff_cur;
  assign den_sel = swap ? diff_pc : diff_cp;

  // Build the job; equal levels become a zero-weight job on the first radius
  always_comb begin
    if (den_sel == '0) begin
      job_num = '0;
      job_den = W'(1);
      job_ylo = previous_radius;
      job_yhi = previous_radius;
    end else begin
      job_num = num_sel[W-1:0];
      job_den = den_sel[W-1:0];
      job_ylo = swap ? sample_radius : previous_radius;
      job_yhi = swap ? previous_radius : sample_radius;
    end
  end

  assign job_push = accept && hit;
  assign job_data = JOB_W'({job_num, job_den, job_ylo, job_yhi});

  // Target register
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (cfg_write) begin
      target <= target_level;
    end
  end

  // Stored profile point
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level  <= '0;
      previous_radius <= '0;
      have_previous   <= 1'b0;
    end else if (accept) begin
      previous_level  <= sample_level;
      previous_radius <= sample_radius;
      have_previous   <= 1'b1;
    end
  end

endmodule

// ----- rtl/core/lci_job_queue.sv -----
module lci_job_queue #(
  parameter int DATA_W = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic [DATA_W-1:0] rd_data,
  output logic              q_empty
);

  import lci_pkg::*;

  localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);

  logic [DATA_W-1:0] slots [JOB_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_wr, do_rd;

  assign q_full  = (fill == CNT_W'(JOB_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(JOB_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/lci_back.sv -----
module lci_back #(
  parameter int VALUE_WIDTH   = 32,
  parameter int FRACTION_BITS = 16,
  parameter int JOB_W         = 4 * 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_empty,
  input  logic [JOB_W-1:0]       job_data,
  output logic                   job_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [VALUE_WIDTH-1:0] crossing_radius
);

  import lci_pkg::*;

  localparam int W     = VALUE_WIDTH;
  localparam int F     = FRACTION_BITS;
  localparam int QW    = F + 1;
  localparam int PW    = W + F + 1;
  localparam int CNT_W = (F > 0) ? $clog2(F + 1) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]       state;
  logic [W-1:0]     rem, den, diff, base, res;
  logic [QW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             up;
  logic [PW-1:0]    prod;
  logic             out_valid;
  logic             hand_over;

  logic [W-1:0] in_num, in_den, in_ylo, in_yhi;
  logic [W:0]   shifted, den_x;
  logic         step_bit;
  logic [W-1:0] mag;

  // Job fields
  assign in_num = job_data[3*W +: W];
  assign in_den = job_data[2*W +: W];
  assign in_ylo = job_data[W +: W];
  assign in_yhi = job_data[0 +: W];

  assign job_pop = (state == ST_IDLE) && !job_empty;

  // One restoring division step
  assign shifted  = {rem, 1'b0};
  assign den_x    = {1'b0, den};
  assign step_bit = (shifted >= den_x);

  // Weighted radius difference, fraction dropped
  assign mag = prod[F +: W];

  // Finished result moves to the output register once it is free
  assign hand_over = (state == ST_HOLD) && (!out_valid || pop);

  assign empty           = !out_valid;
  assign crossing_radius = res;

  // Interpolation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            // First quotient bit: set only when target sits on the low level
            if (in_num >= in_den) begin
              rem <= in_num - in_den;
              quo <= QW'(1);
            end else begin
              rem <= in_num;
              quo <= '0;
            end
            den  <= in_den;
            up   <= (in_ylo >= in_yhi);
            diff <= (in_ylo >= in_yhi) ? in_ylo - in_yhi : in_yhi - in_ylo;
            base <= in_yhi;
            cnt  <= CNT_W'(F - 1);
            state <= (F > 0) ? ST_DIV : ST_MUL;
          end
        end
        ST_DIV: begin
          rem <= step_bit ? W'(shifted - den_x) : shifted[W-1:0];
          quo <= (quo << 1) | QW'(step_bit);
          if (cnt == '0) begin
            state <= ST_MUL;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end
        ST_MUL: begin
          prod  <= PW'(quo) * PW'(diff);
          state <= ST_ADD;
        end
        ST_ADD: begin
          base  <= up ? base + mag : base - mag;
          state <= ST_HOLD;
        end
        ST_HOLD: begin
          if (hand_over) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register; a waiting result leaves on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hand_over) begin
      res       <= base;
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import lci_pkg::*;

  localparam int VW = VALUE_WIDTH_DEF;
  localparam int FB = FRACTION_BITS_DEF;
  // cycles to let a point with no crossing clear the block before a register write
  localparam int SETTLE_CYCLES = FB + 24;
  localparam longint LEVEL_MAX = 64'sd2147483647;
  localparam longint LEVEL_MIN = -64'sd2147483648;

  typedef enum int {POP_ALWAYS, POP_HALF, POP_RARE, POP_STALL} pop_mode_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic signed [VW-1:0] target_level;
  logic                 push;
  logic                 full;
  logic signed [VW-1:0] sample_level;
  logic        [VW-1:0] sample_radius;
  logic                 first_point;
  logic                 pop;
  logic                 empty;
  logic        [VW-1:0] crossing_radius;

  // predictor state
  logic signed [VW-1:0] model_target;
  logic signed [VW-1:0] held_level;
  logic        [VW-1:0] held_radius;
  bit                   held_valid;
  logic        [VW-1:0] last_radius;

  logic [VW-1:0] crossings_due[$];
  int errors;
  int points_sent;
  int crossings_checked;
  int target_settings;
  int burst_left;

  level_crossing_interpolator_top DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .target_level    (target_level),
    .push            (push),
    .full            (full),
    .sample_level    (sample_level),
    .sample_radius   (sample_radius),
    .first_point     (first_point),
    .pop             (pop),
    .empty           (empty),
    .crossing_radius (crossing_radius)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall limit on the run
  initial begin
    #10ms;
    $display("Timeout at %0t: results still outstanding: %0d", $time, crossings_due.size());
    $display("TEST FAILED");
    $finish;
  end

  // Works out the crossing radius for one accepted point and updates the held point.
  function automatic bit predict_crossing(input logic signed [VW-1:0] lvl,
                                          input logic [VW-1:0] rad, input logic fp,
                                          output logic [VW-1:0] radius_out);
    longint cur, prev, tgt, lo, hi, dp, dc;
    longint unsigned ylo, yhi, num, den, w, d, m, r;
    bit hit;
    hit = 1'b0;
    radius_out = '0;
    if (!fp && held_valid) begin
      cur  = longint'(lvl);
      prev = longint'(held_level);
      tgt  = longint'(model_target);
      dp = prev - tgt;
      dc = cur - tgt;
      hit = (dp == 0) || (dc == 0) || ((dp < 0) != (dc < 0));
      if (hit) begin
        if (prev > cur) begin
          lo = cur; ylo = rad; hi = prev; yhi = held_radius;
        end else begin
          lo = prev; ylo = held_radius; hi = cur; yhi = rad;
        end
        if (lo == hi) begin
          r = held_radius;
        end else if (tgt == hi) begin
          r = yhi;
        end else begin
          num = longint'(hi - tgt);
          den = longint'(hi - lo);
          w = (num << FB) / den;
          d = (ylo >= yhi) ? (ylo - yhi) : (yhi - ylo);
          m = (w * d) >> FB;
          r = (ylo >= yhi) ? (yhi + m) : (yhi - m);
        end
        radius_out = r[VW-1:0];
      end
    end
    held_level  = lvl;
    held_radius = rad;
    held_valid  = 1'b1;
    return hit;
  endfunction

  function automatic logic signed [VW-1:0] q16(input int whole);
    return whole <<< FB;
  endfunction

  // level on a chosen side of the target, within 2^span_log of it, clamped to range
  function automatic logic signed [VW-1:0] level_near(input int span_log, input bit side);
    longint mag, v;
    if ($urandom_range(0, 15) == 0) return model_target;
    mag = longint'($urandom_range(0, 1 << span_log));
    v = side ? longint'(model_target) + mag : longint'(model_target) - mag;
    if (v > LEVEL_MAX) v = LEVEL_MAX;
    if (v < LEVEL_MIN) v = LEVEL_MIN;
    return v[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] pick_radius();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return last_radius;
    return $urandom;
  endfunction

  // push held low for a number of cycles
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  // one point transfer; push stays high until the caller idles or sends again
  task automatic send_point(input logic signed [VW-1:0] lvl, input logic [VW-1:0] rad,
                            input logic fp);
    logic [VW-1:0] expected;
    @(negedge clk);
    push          <= 1'b1;
    sample_level  <= lvl;
    sample_radius <= rad;
    first_point   <= fp;
    @(posedge clk);
    while (full) @(posedge clk);
    if (predict_crossing(lvl, rad, fp, expected)) crossings_due = {crossings_due, expected};
    last_radius = rad;
    points_sent++;
  endtask

  // sender bursts with random gaps, sometimes long runs with none
  task automatic pace_sender();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  // wait for every outstanding crossing, then let the pipeline settle
  task automatic drain_results();
    hold_off(1);
    while (crossings_due.size() != 0) @(posedge clk);
    hold_off(SETTLE_CYCLES);
  endtask

  task automatic set_target(input logic signed [VW-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_write    <= 1'b1;
    target_level <= value;
    @(negedge clk);
    cfg_write    <= 1'b0;
    model_target = value;
    target_settings++;
  endtask

  // random profiles: mostly well-formed scans around the target, some noise
  task automatic run_profiles(input int quota);
    int start, kind, n, span_log;
    bit side;
    start = points_sent;
    while (points_sent - start < quota) begin
      kind = $urandom_range(0, 9);
      span_log = $urandom_range(1, 30);
      side = 1'($urandom_range(0, 1));
      if (kind <= 6) begin
        n = $urandom_range(2, 10);
        for (int i = 0; i <= n; i++) begin
          pace_sender();
          send_point(level_near(span_log, side), pick_radius(), i == 0);
          if ($urandom_range(0, 9) < 7) side = !side;
        end
      end else if (kind <= 8) begin
        pace_sender();
        send_point($urandom, $urandom, $urandom_range(0, 3) == 0);
      end else begin
        // carry on from whatever point is held, no restart
        n = $urandom_range(1, 4);
        repeat (n) begin
          pace_sender();
          send_point(level_near(span_log, 1'($urandom_range(0, 1))), pick_radius(), 1'b0);
        end
      end
    end
  endtask

  // target at its reset value of zero
  task automatic test_reset_target();
    send_point(q16(5), q16(100), 1'b0);           // nothing held yet: no result
    send_point(q16(-3), q16(40), 1'b0);           // falling crossing, pair swapped
    send_point(q16(0), q16(7), 1'b0);             // target on the higher level
    send_point(q16(0), q16(9), 1'b0);             // equal levels at target
    send_point(q16(2), 32'd0, 1'b0);              // previous level on target
    send_point(q16(2), 32'd5, 1'b0);              // equal levels off target: no result
    send_point(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_point(32'sh8000_0000, 32'h0000_0000, 1'b0);  // full-range segment
    send_point(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'shFFFF_FFFF, 32'h1234_5678, 1'b1);  // restart
    send_point(32'sh0000_0001, 32'h1234_5678, 1'b0);  // equal radii
  endtask

  // target at both ends of its range; held point survives the writes
  task automatic test_extreme_targets();
    set_target(32'sh8000_0000);
    send_point(32'sh8000_0000, 32'd3, 1'b0);
    send_point(32'sh8000_0000, 32'd8, 1'b0);
    set_target(32'sh7FFF_FFFF);
    send_point(32'sh7FFF_FFFF, 32'd77, 1'b0);
    send_point(q16(5), 32'd1, 1'b1);
    send_point(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
  endtask

  // fractional target, rising and falling interpolation
  task automatic test_fractional_target();
    set_target(32'sh0001_8000);
    send_point(q16(1), q16(10), 1'b1);
    send_point(q16(2), q16(20), 1'b0);
    send_point(q16(-1), 32'h0000_0001, 1'b0);
    send_point(q16(3), 32'hFFFF_FFFE, 1'b0);
  endtask

  task automatic test_random_profiles();
    set_target($urandom);
    run_profiles(170);
    set_target(32'sh7FFF_FFFA);
    run_profiles(170);
    set_target(32'sh8000_0003);
    run_profiles(85);
    drain_results();      // sender waits for every crossing mid-phase
    run_profiles(85);
    set_target($urandom);
    run_profiles(170);
    set_target('0);
    run_profiles(170);
  endtask

  // receiver stall pattern
  initial begin
    pop_mode_t mode;
    int span;
    pop = 1'b0;
    forever begin
      mode = pop_mode_t'($urandom_range(0, 3));
      span = $urandom_range(1, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          POP_ALWAYS: pop <= 1'b1;
          POP_HALF:   pop <= 1'($urandom_range(0, 1));
          POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
          default:    pop <= 1'b0;
        endcase
      end
    end
  end

  // compare each result transfer with the oldest expected crossing
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (crossings_due.size() == 0) begin
        $display("%0t: unexpected crossing_radius, expected none, actual %h",
                 $time, crossing_radius);
        errors++;
      end else begin
        if (crossing_radius !== crossings_due[0]) begin
          $display("%0t: crossing_radius mismatch, expected %h, actual %h",
                   $time, crossings_due[0], crossing_radius);
          errors++;
        end
        void'(crossings_due.pop_front());
        crossings_checked++;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_write     = 1'b0;
    target_level  = '0;
    push          = 1'b0;
    sample_level  = '0;
    sample_radius = '0;
    first_point   = 1'b0;
    model_target  = '0;
    held_level    = '0;
    held_radius   = '0;
    held_valid    = 1'b0;
    last_radius   = '0;
    errors = 0;
    points_sent = 0;
    crossings_checked = 0;
    target_settings = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_target();
    test_extreme_targets();
    test_fractional_target();
    test_random_profiles();
    drain_results();

    $display("Run covered %0d points and %0d crossing results over %0d target writes",
             points_sent, crossings_checked, target_settings);
    $display("Mismatches and stray results: %0d", errors);
    if (errors == 0 && crossings_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/lci_pkg.sv
rtl/core/lci_front.sv
rtl/core/lci_job_queue.sv
rtl/core/lci_back.sv
rtl/core/level_crossing_interpolator_top.sv
bench/testbench.sv
